/* hw/rtl/u8d_pkg.sv */
// shared types and constants of the utf-8 byte stream decoder
package u8d_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int CP_W    = 21;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_CONT,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_BAD
    } byte_kind_t;

    typedef enum logic [1:0] {
        ST_ONGOING = 2'd0,
        ST_DONE    = 2'd1,
        ST_ERROR   = 2'd2,
        ST_PARTIAL = 2'd3
    } status_t;

    typedef struct packed {
        byte_kind_t  kind;
        logic [7:0]  data;
        logic        eos;
    } item_t;

    function automatic byte_kind_t classify(input logic [7:0] b);
        byte_kind_t k;
        if (b < 8'h80)
            k = KIND_ASCII;
        else if ((b & 8'hC0) == 8'h80)
            k = KIND_CONT;
        else if (b >= 8'hC2 && b <= 8'hDF)
            k = KIND_LEAD2;
        else if (b >= 8'hE0 && b <= 8'hEF)
            k = KIND_LEAD3;
        else if (b >= 8'hF0 && b <= 8'hF4)
            k = KIND_LEAD4;
        else
            k = KIND_BAD;
        return k;
    endfunction

endpackage

/* hw/rtl/u8d_front.sv */
// front end: takes input bytes and tags each with its byte class
module u8d_front
    import u8d_pkg::*;
(
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        end_of_string,
    output logic        push,
    output item_t       push_item,
    input  logic        q_full
);

    assign in_ready       = !q_full;
    assign push           = in_valid && !q_full;
    assign push_item.kind = classify(byte_in);
    assign push_item.data = byte_in;
    assign push_item.eos  = end_of_string;

endmodule

/* hw/rtl/u8d_queue.sv */
// small queue of classified bytes between front and back
module u8d_queue
    import u8d_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  item_t  push_item,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output item_t  head
);

    item_t                mem [Q_DEPTH];
    logic [Q_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]        count_reg, count_next;

    assign full      = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

/* hw/rtl/u8d_back.sv */
// back end: sequence state and the registered result
module u8d_back
    import u8d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             not_empty,
    input  item_t            head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CP_W-1:0]  code_point,
    output logic             char_valid,
    output logic [1:0]       status
);

    logic [1:0]        pending_reg, pending_next;
    logic [CP_W-1:0]   partial_reg, partial_next;
    logic              discarding_reg, discarding_next;

    logic              out_valid_reg, out_valid_next;
    logic [CP_W-1:0]   code_point_reg, code_point_next;
    logic              char_valid_reg, char_valid_next;
    status_t           status_reg, status_next;

    logic              emit;
    logic [CP_W-1:0]   emit_cp;
    logic              emit_cv;
    status_t           emit_st;
    logic [CP_W-1:0]   shifted;

    assign pop     = not_empty && (!out_valid_reg || out_ready);
    assign shifted = {partial_reg[CP_W-7:0], head.data[5:0]};

    always_comb
    begin
        pending_next    = pending_reg;
        partial_next    = partial_reg;
        discarding_next = discarding_reg;
        emit            = 1'b0;
        emit_cp         = '0;
        emit_cv         = 1'b0;
        emit_st         = ST_ONGOING;
        if (pop)
        begin
            if (discarding_reg)
            begin
                if (head.eos)
                    discarding_next = 1'b0;
            end
            else if (pending_reg != 2'd0)
            begin
                if (head.kind == KIND_CONT)
                begin
                    if (pending_reg == 2'd1)
                    begin
                        emit         = 1'b1;
                        emit_cp      = shifted;
                        emit_cv      = 1'b1;
                        emit_st      = head.eos ? ST_DONE : ST_ONGOING;
                        pending_next = 2'd0;
                        partial_next = '0;
                    end
                    else if (head.eos)
                    begin
                        emit         = 1'b1;
                        emit_st      = ST_PARTIAL;
                        pending_next = 2'd0;
                        partial_next = '0;
                    end
                    else
                    begin
                        pending_next = pending_reg - 2'd1;
                        partial_next = shifted;
                    end
                end
                else
                begin
                    // missing continuation: zero byte counts as truncation
                    emit            = 1'b1;
                    emit_st         = (head.data == 8'h00) ? ST_PARTIAL : ST_ERROR;
                    pending_next    = 2'd0;
                    partial_next    = '0;
                    discarding_next = !head.eos;
                end
            end
            else
            begin
                unique case (head.kind)
                    KIND_ASCII:
                    begin
                        emit    = 1'b1;
                        emit_cp = CP_W'(head.data);
                        emit_cv = 1'b1;
                        emit_st = head.eos ? ST_DONE : ST_ONGOING;
                    end
                    KIND_LEAD2, KIND_LEAD3, KIND_LEAD4:
                    begin
                        if (head.eos)
                        begin
                            emit    = 1'b1;
                            emit_st = ST_PARTIAL;
                        end
                        else if (head.kind == KIND_LEAD2)
                        begin
                            pending_next = 2'd1;
                            partial_next = CP_W'(head.data & 8'h1F);
                        end
                        else if (head.kind == KIND_LEAD3)
                        begin
                            pending_next = 2'd2;
                            partial_next = CP_W'(head.data & 8'h0F);
                        end
                        else
                        begin
                            pending_next = 2'd3;
                            partial_next = CP_W'(head.data & 8'h07);
                        end
                    end
                    default:
                    begin
                        emit            = 1'b1;
                        emit_st         = ST_ERROR;
                        discarding_next = !head.eos;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        code_point_next = code_point_reg;
        char_valid_next = char_valid_reg;
        status_next     = status_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            code_point_next = emit_cp;
            char_valid_next = emit_cv;
            status_next     = emit_st;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 2'd0;
            partial_reg    <= '0;
            discarding_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pending_reg    <= pending_next;
            partial_reg    <= partial_next;
            discarding_reg <= discarding_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_point_reg <= code_point_next;
        char_valid_reg <= char_valid_next;
        status_reg     <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_point_reg;
    assign char_valid = char_valid_reg;
    assign status     = status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        discarding_reg |-> (pending_reg == 2'd0))
        else $error("drop mode with open sequence");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 2'd0) |-> (partial_reg == '0))
        else $error("stale partial value");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && char_valid_reg) |->
        (status_reg == ST_DONE || status_reg == ST_ONGOING))
        else $error("code point with failure status");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !char_valid_reg) |-> (code_point_reg == '0))
        else $error("nonzero code point without char_valid");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped while stalled");

endmodule

/* hw/rtl/utf8_byte_stream_decoder.sv */
// utf-8 byte stream decoder top level
// Decodes a UTF-8 string fed one byte per transfer; end_of_string marks the
// last byte. A new byte is taken every cycle as long as the two-entry queue
// between the classifying front end and the decoding back end has room, and
// the back end retires one byte per cycle whenever its output register is free
// or being taken. Sustained rate is one byte per cycle while out_ready stays
// high; a byte is written into the queue and its result into the output
// register before the result is valid on the output. Bytes that finish no
// character and raise no status give no output transfer.
module utf8_byte_stream_decoder
    import u8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        byte_in,
    input  logic              end_of_string,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CP_W-1:0]   code_point,
    output logic              char_valid,
    output logic [1:0]        status
);

    logic   push;
    item_t  push_item;
    logic   q_full;
    logic   pop;
    logic   not_empty;
    item_t  head;

    u8d_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_in       (byte_in),
        .end_of_string (end_of_string),
        .push          (push),
        .push_item     (push_item),
        .q_full        (q_full)
    );

    u8d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .char_valid (char_valid),
        .status     (status)
    );

endmodule

/* tb/sv/tb_utf8_byte_stream_decoder.sv */
// self-checking testbench for the utf-8 byte stream decoder
`timescale 1ns / 100ps

module tb_utf8_byte_stream_decoder
    import u8d_pkg::*;
();

    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 16;
    localparam int RAND_BYTES  = 1250;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       pause;
    } byte_item_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            valid;
        status_t         st;
    } char_result_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_QUARTER,
        RX_BURSTY
    } rx_mode_t;

    logic            clk           = 1'b0;
    logic            rst_n         = 1'b0;
    logic            in_valid      = 1'b0;
    logic            in_ready;
    logic [7:0]      byte_in       = 8'h00;
    logic            end_of_string = 1'b0;
    logic            out_valid;
    logic            out_ready     = 1'b0;
    logic [CP_W-1:0] code_point;
    logic            char_valid;
    logic [1:0]      status;

    byte_item_t   tx_bytes[$];
    char_result_t expected_chars[$];
    logic [7:0]   str_buf[$];

    // predictor state
    logic [1:0]      seq_left  = '0;
    logic [CP_W-1:0] seq_acc   = '0;
    logic            skip_rest = 1'b0;

    int         mismatch_cnt = 0;
    int         idle_cycles  = 0;
    int         gap_left     = 0;
    int         burst_left   = 0;
    int         mode_left    = 0;
    int         stall_left   = 0;
    int         rx_phase     = 0;
    rx_mode_t   rx_mode      = RX_ALWAYS;
    bit         pause_next   = 1'b0;
    byte_item_t   drv_item;
    char_result_t drv_res;
    char_result_t mon_exp;

    utf8_byte_stream_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_in       (byte_in),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_point    (code_point),
        .char_valid    (char_valid),
        .status        (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got 'h%0h expected 'h%0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic void clear_decoder();
        seq_left  = '0;
        seq_acc   = '0;
        skip_rest = 1'b0;
    endfunction

    // returns 1 when the byte yields a result transfer
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output char_result_t r);
        r    = '0;
        r.st = ST_ONGOING;
        if (skip_rest)
        begin
            if (last)
                clear_decoder();
            return 1'b0;
        end
        if (seq_left != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                seq_acc  = {seq_acc[CP_W-7:0], b[5:0]};
                seq_left = seq_left - 2'd1;
                if (seq_left == 2'd0)
                begin
                    r.cp    = seq_acc;
                    r.valid = 1'b1;
                    r.st    = last ? ST_DONE : ST_ONGOING;
                    clear_decoder();
                    return 1'b1;
                end
                if (last)
                begin
                    clear_decoder();
                    r.st = ST_PARTIAL;
                    return 1'b1;
                end
                return 1'b0;
            end
            // continuation missing: a zero byte counts as truncation
            r.st = (b == 8'h00) ? ST_PARTIAL : ST_ERROR;
            clear_decoder();
            skip_rest = !last;
            return 1'b1;
        end
        if (b < 8'h80)
        begin
            r.cp    = {13'd0, b};
            r.valid = 1'b1;
            r.st    = last ? ST_DONE : ST_ONGOING;
            if (last)
                clear_decoder();
            return 1'b1;
        end
        if (b >= 8'hC2 && b <= 8'hDF)
        begin
            seq_acc  = {16'd0, b[4:0]};
            seq_left = 2'd1;
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            seq_acc  = {17'd0, b[3:0]};
            seq_left = 2'd2;
        end
        else if (b >= 8'hF0 && b <= 8'hF4)
        begin
            seq_acc  = {18'd0, b[2:0]};
            seq_left = 2'd3;
        end
        else
        begin
            r.st = ST_ERROR;
            clear_decoder();
            skip_rest = !last;
            return 1'b1;
        end
        if (last)
        begin
            clear_decoder();
            r.st = ST_PARTIAL;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        byte_item_t it;
        it.b       = b;
        it.last    = last;
        it.pause   = pause_next;
        pause_next = 1'b0;
        tx_bytes.push_back(it);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic add_char(input int nbytes);
        int k;
        case (nbytes)
            1: str_buf.push_back(8'($urandom_range(0, 127)));
            2: str_buf.push_back(8'($urandom_range('hC2, 'hDF)));
            3: str_buf.push_back(8'($urandom_range('hE0, 'hEF)));
            default: str_buf.push_back(8'($urandom_range('hF0, 'hF4)));
        endcase
        for (k = 1; k < nbytes; k++)
            str_buf.push_back(cont_byte());
    endtask

    task automatic gen_string();
        int n;
        int k;
        int pos;
        int flavor;
        str_buf.delete();
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
            add_char($urandom_range(1, 4));
        // one string in five is damaged somewhere
        if ($urandom_range(0, 4) == 0)
        begin
            flavor = $urandom_range(0, 4);
            pos    = $urandom_range(0, str_buf.size() - 1);
            case (flavor)
                0: if (str_buf.size() > 1) void'(str_buf.pop_back());
                1: str_buf.insert(pos, 8'h00);
                2: str_buf.insert(pos, 8'($urandom_range(0, 255)));
                3: str_buf[pos] = 8'($urandom_range(0, 255));
                default:
                begin
                    for (k = 0; k < 4; k++)
                        str_buf.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        for (k = 0; k < str_buf.size(); k++)
            push_byte(str_buf[k], k == str_buf.size() - 1);
    endtask

    // sender: bursts with random gaps, prediction at each input transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (decode_byte(byte_in, end_of_string, drv_res))
                    expected_chars.push_back(drv_res);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left == 0 && burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    flavor_gap();
                end
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() != 0 &&
                         !(tx_bytes[0].pause && expected_chars.size() != 0))
                begin
                    drv_item = tx_bytes.pop_front();
                    in_valid      <= 1'b1;
                    byte_in       <= drv_item.b;
                    end_of_string <= drv_item.last;
                    burst_left--;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic flavor_gap();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            gap_left = 0;
        else if (pick < 9)
            gap_left = $urandom_range(1, 4);
        else
            gap_left = $urandom_range(5, 20);
    endtask

    // receiver: stall pattern switches between a few modes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_ALWAYS:  out_ready <= 1'b1;
                RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                RX_QUARTER: out_ready <= (rx_phase % 4 == 0);
                default:
                begin
                    if (stall_left != 0)
                    begin
                        stall_left--;
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        out_ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch("result with nothing expected", int'(code_point), 0);
            end
            else
            begin
                mon_exp = expected_chars.pop_front();
                if (code_point !== mon_exp.cp)
                    report_mismatch("code_point", int'(code_point), int'(mon_exp.cp));
                if (char_valid !== mon_exp.valid)
                    report_mismatch("char_valid", int'(char_valid), int'(mon_exp.valid));
                if (status !== mon_exp.st)
                    report_mismatch("status", int'(status), int'(mon_exp.st));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int n_strings;

        // plain bytes at both ends of the ascii range, zero as a character
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b1);
        // smallest and largest two-byte values, smallest three-byte and largest four-byte value
        push_byte(8'hC2, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hDF, 1'b0);
        push_byte(8'hBF, 1'b1);
        push_byte(8'hE0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'hF4, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b1);
        // stray continuation, then the rest of the string is dropped
        push_byte(8'h80, 1'b0);
        push_byte(8'h41, 1'b1);
        // zero byte where a continuation belongs
        push_byte(8'hC2, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        // lead byte as the last byte, then a sequence cut short at the end
        push_byte(8'hE0, 1'b1);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h90, 1'b1);
        // wrong byte in place of a continuation on the last byte
        push_byte(8'hC2, 1'b0);
        push_byte(8'h41, 1'b1);
        // invalid leads
        push_byte(8'hC0, 1'b1);
        push_byte(8'hF5, 1'b1);

        n_strings = 0;
        while (tx_bytes.size() < RAND_BYTES)
        begin
            if (n_strings % 40 == 0)
                pause_next = 1'b1;
            gen_string();
            n_strings++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (tx_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_chars.size() != 0)
            report_mismatch("results never arrived", 0, expected_chars.size());
        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_front.sv
hw/rtl/u8d_queue.sv
hw/rtl/u8d_back.sv
hw/rtl/utf8_byte_stream_decoder.sv
tb/sv/tb_utf8_byte_stream_decoder.sv
